/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers; compiled out when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every edge outside reset
`define ASSERT_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// ante in this cycle implies cons in the next one
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_RST(label, clk, rst_n, prop, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

/* hdl/qat_pkg.sv */
// ----------------------------------------------------------------------------
// qat_pkg
// Types and constants shared by the quoted argument tokenizer.
// ----------------------------------------------------------------------------
package qat_pkg;

    localparam int MAX_TOKENS = 32;
    localparam int MAX_BYTES  = 4096;

    localparam int TOK_W  = $clog2(MAX_TOKENS + 1);
    localparam int BYTE_W = $clog2(MAX_BYTES);

    // result queue: one request may push up to three results
    localparam int PUSH_MAX = 3;
    localparam int PUSH_W   = $clog2(PUSH_MAX + 1);
    localparam int QDEPTH   = 4;
    localparam int QPTR_W   = $clog2(QDEPTH);
    localparam int CNT_W    = $clog2(QDEPTH + 1);

    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;

    typedef enum logic [3:0] {
        MODE_IDLE   = 4'b0001,
        MODE_BARE   = 4'b0010,
        MODE_QFIRST = 4'b0100,
        MODE_QUOTED = 4'b1000
    } t_mode;

    typedef enum logic [1:0] {
        KIND_CHAR = 2'd0,
        KIND_END  = 2'd1,
        KIND_DONE = 2'd2
    } t_kind;

    typedef struct packed {
        t_mode              mode;
        logic               prev_bs;
        logic               esc;
        logic [TOK_W-1:0]   tokens;
        logic [BYTE_W-1:0]  bytes;
    } t_scan_state;

    localparam t_scan_state SCAN_RESET = '{
        mode: MODE_IDLE, prev_bs: 1'b0, esc: 1'b0, tokens: '0, bytes: '0
    };

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  tbyte;
        logic [4:0]  num;
        logic [5:0]  total;
        logic        last;
    } t_result;

    typedef t_result [PUSH_MAX-1:0] t_res_arr;

endpackage

/* hdl/qat_req_if.sv */
// ----------------------------------------------------------------------------
// qat_req_if
// Byte request channel: one string byte or end marker per request.
// ----------------------------------------------------------------------------
interface qat_req_if;
    logic        valid;
    logic        ready;
    logic [7:0]  byte_value;
    logic        end_of_string;

    modport source (output valid, output byte_value, output end_of_string, input ready);
    modport sink   (input valid, input byte_value, input end_of_string, output ready);
endinterface

/* hdl/qat_rsp_if.sv */
// ----------------------------------------------------------------------------
// qat_rsp_if
// Result channel: token characters, token ends and string summaries.
// ----------------------------------------------------------------------------
interface qat_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  event_kind;
    logic [7:0]  token_byte;
    logic [4:0]  token_number;
    logic [5:0]  token_total;
    logic        last_of_run;

    modport source (output valid, output event_kind, output token_byte,
                    output token_number, output token_total, output last_of_run,
                    input ready);
    modport sink   (input valid, input event_kind, input token_byte,
                    input token_number, input token_total, input last_of_run,
                    output ready);
endinterface

/* hdl/qat_step.sv */
// ----------------------------------------------------------------------------
// qat_step
// Next scan state and results for one request.
// ----------------------------------------------------------------------------
module qat_step
    import qat_pkg::*;
(
    input  t_scan_state       i_state,
    input  logic [7:0]        i_byte,
    input  logic              i_eos,
    output t_scan_state       o_state,
    output t_res_arr          o_res,
    output logic [PUSH_W-1:0] o_cnt
);

    function automatic t_result mk_res(t_kind kind, logic [7:0] tb,
                                       logic [4:0] num, logic [5:0] total);
        t_result r;
        r.kind  = kind;
        r.tbyte = tb;
        r.num   = num;
        r.total = total;
        r.last  = 1'b0;
        return r;
    endfunction

    logic [4:0]       tok_num;
    logic [TOK_W-1:0] tok_inc;
    logic             blank;
    t_res_arr         res;

    assign tok_num = 5'(i_state.tokens);
    assign tok_inc = i_state.tokens + TOK_W'(1);
    assign blank   = i_byte inside {CH_SPACE, CH_TAB, CH_CR, CH_LF};

    always_comb begin
        o_state = i_state;
        res     = '0;
        o_cnt   = '0;
        if (i_eos) begin
            o_state = SCAN_RESET;
            if (i_state.mode != MODE_IDLE) begin
                if (i_state.mode != MODE_BARE && i_state.esc) begin
                    // dangling backslash kept as a literal
                    res[0] = mk_res(KIND_CHAR, CH_BSLASH, tok_num, 6'd0);
                    res[1] = mk_res(KIND_END, 8'd0, tok_num, 6'd0);
                    res[2] = mk_res(KIND_DONE, 8'd0, 5'd0, 6'(tok_inc));
                    o_cnt  = PUSH_W'(3);
                end else begin
                    res[0] = mk_res(KIND_END, 8'd0, tok_num, 6'd0);
                    res[1] = mk_res(KIND_DONE, 8'd0, 5'd0, 6'(tok_inc));
                    o_cnt  = PUSH_W'(2);
                end
            end else begin
                res[0] = mk_res(KIND_DONE, 8'd0, 5'd0, 6'(i_state.tokens));
                o_cnt  = PUSH_W'(1);
            end
        end else if (i_state.bytes >= BYTE_W'(MAX_BYTES - 1)) begin
            // past the length limit: ignored
        end else if (i_byte == 8'd0) begin
            // NUL truncates the rest of the string
            o_state.bytes = BYTE_W'(MAX_BYTES - 1);
        end else begin
            o_state.bytes = i_state.bytes + BYTE_W'(1);
            case (i_state.mode)
                MODE_IDLE: begin
                    if (!blank && i_state.tokens < TOK_W'(MAX_TOKENS)) begin
                        if (i_byte == CH_QUOTE) begin
                            o_state.mode    = MODE_QFIRST;
                            o_state.prev_bs = 1'b0;
                            o_state.esc     = 1'b0;
                        end else begin
                            o_state.mode = MODE_BARE;
                            res[0] = mk_res(KIND_CHAR, i_byte, tok_num, 6'd0);
                            o_cnt  = PUSH_W'(1);
                        end
                    end
                end
                MODE_BARE: begin
                    if (blank) begin
                        res[0]          = mk_res(KIND_END, 8'd0, tok_num, 6'd0);
                        o_cnt           = PUSH_W'(1);
                        o_state.tokens  = tok_inc;
                        o_state.mode    = MODE_IDLE;
                        o_state.prev_bs = 1'b0;
                        o_state.esc     = 1'b0;
                    end else begin
                        res[0] = mk_res(KIND_CHAR, i_byte, tok_num, 6'd0);
                        o_cnt  = PUSH_W'(1);
                    end
                end
                MODE_QFIRST, MODE_QUOTED: begin
                    if (i_byte == CH_QUOTE && i_state.mode == MODE_QUOTED
                            && !i_state.prev_bs) begin
                        res[0]          = mk_res(KIND_END, 8'd0, tok_num, 6'd0);
                        o_cnt           = PUSH_W'(1);
                        o_state.tokens  = tok_inc;
                        o_state.mode    = MODE_IDLE;
                        o_state.prev_bs = 1'b0;
                        o_state.esc     = 1'b0;
                    end else begin
                        if (i_state.esc) begin
                            res[0]      = mk_res(KIND_CHAR, i_byte, tok_num, 6'd0);
                            o_cnt       = PUSH_W'(1);
                            o_state.esc = 1'b0;
                        end else if (i_byte == CH_BSLASH) begin
                            o_state.esc = 1'b1;
                        end else begin
                            res[0] = mk_res(KIND_CHAR, i_byte, tok_num, 6'd0);
                            o_cnt  = PUSH_W'(1);
                        end
                        o_state.prev_bs = (i_byte == CH_BSLASH);
                        o_state.mode    = MODE_QUOTED;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // flag the final result of the run
    always_comb begin
        o_res = res;
        for (int k = 0; k < PUSH_MAX; k++) begin
            o_res[k].last = (o_cnt == PUSH_W'(k + 1));
        end
    end

endmodule

/* hdl/qat_result_q.sv */
// ----------------------------------------------------------------------------
// qat_result_q
// Small result queue; takes up to three results a cycle, drains one on o_rsp.ready.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module qat_result_q
    import qat_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [PUSH_W-1:0] i_push_n,
    input  t_res_arr          i_push,
    output logic              o_space,
    qat_rsp_if.source         o_rsp
);

    t_result            r_mem [QDEPTH];
    logic [QPTR_W-1:0]  r_wr;
    logic [QPTR_W-1:0]  r_rd;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    logic               pop;

    assign pop     = o_rsp.valid && o_rsp.ready;
    assign n_count = r_count + CNT_W'(i_push_n) - CNT_W'(pop);
    assign o_space = r_count <= CNT_W'(QDEPTH - PUSH_MAX);

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < PUSH_MAX; k++) begin
            if (PUSH_W'(k) < i_push_n) begin
                r_mem[r_wr + QPTR_W'(k)] <= i_push[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= r_wr + QPTR_W'(i_push_n);
            r_rd    <= r_rd + QPTR_W'(pop);
            r_count <= n_count;
        end
    end

    assign o_rsp.valid        = (r_count != '0);
    assign o_rsp.event_kind   = r_mem[r_rd].kind;
    assign o_rsp.token_byte   = r_mem[r_rd].tbyte;
    assign o_rsp.token_number = r_mem[r_rd].num;
    assign o_rsp.token_total  = r_mem[r_rd].total;
    assign o_rsp.last_of_run  = r_mem[r_rd].last;

    `ASSERT_RST(a_q_bound, i_clk, i_rst_n, r_count <= CNT_W'(QDEPTH), "result queue overfull")
    `ASSERT_RST(a_q_room, i_clk, i_rst_n, (r_count + CNT_W'(i_push_n)) <= CNT_W'(QDEPTH), "push without room")
    `ASSERT_NEXT(a_q_drain, i_clk, i_rst_n, pop && r_count == CNT_W'(1) && i_push_n == '0, r_count == '0, "queue did not empty")

endmodule

/* hdl/quoted_argument_tokenizer_core.sv */
// ----------------------------------------------------------------------------
// quoted_argument_tokenizer_core
// Splits a byte stream into shell-style arguments with quoting.
// ----------------------------------------------------------------------------
// Usage:
//   i_req carries one request per string byte (byte_value) or an end marker
//   (end_of_string). o_rsp returns events: token characters, token ends and,
//   after every end marker, a summary with the token count (last_of_run
//   marks the final event caused by a request).
//   Events of a request enter the result queue when it is taken. Throughput:
//   one byte per cycle while the queue has room; the scan state update is a
//   single level of compare/select logic between the state registers and the
//   result queue. A byte makes at most one event, an end marker up to three,
//   drained one per cycle on o_rsp.ready, so an end marker can hold off input.
//   i_req.ready is high while the four-entry result queue has room for
//   three events, so a stalled receiver stops input once results back up;
//   nothing is dropped.
//   Reset (synchronous, active low) clears scan state and empties the queue;
//   the block is ready in the next cycle. Each end marker also returns the
//   scan state to its reset value for the next string.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module quoted_argument_tokenizer_core
    import qat_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    qat_req_if.sink    i_req,
    qat_rsp_if.source  o_rsp
);

    t_scan_state        r_scan;
    t_scan_state        n_scan;
    t_res_arr           step_res;
    logic [PUSH_W-1:0]  step_cnt;
    logic               q_space;
    logic               accept;
    logic               tok_room;
    logic               eos_taken;
    logic               rsp_stall;

    // room for the worst case keeps every request's events together
    assign i_req.ready = q_space;
    assign accept      = i_req.valid && i_req.ready;

    qat_step u_step (
        .i_state (r_scan),
        .i_byte  (i_req.byte_value),
        .i_eos   (i_req.end_of_string),
        .o_state (n_scan),
        .o_res   (step_res),
        .o_cnt   (step_cnt)
    );

    // scan state advances only on a taken request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan <= SCAN_RESET;
        end else if (accept) begin
            r_scan <= n_scan;
        end
    end

    qat_result_q u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push_n (accept ? step_cnt : PUSH_W'(0)),
        .i_push   (step_res),
        .o_space  (q_space),
        .o_rsp    (o_rsp)
    );

    // an open token always has a slot under the token limit
    assign tok_room  = (r_scan.mode == MODE_IDLE) || (r_scan.tokens < TOK_W'(MAX_TOKENS));
    assign eos_taken = accept && i_req.end_of_string;
    assign rsp_stall = o_rsp.valid && !o_rsp.ready;

    `ASSERT_RST(a_tok_limit, i_clk, i_rst_n, tok_room, "token open past limit")
    // end marker restores the between-strings state
    `ASSERT_NEXT(a_eos_clear, i_clk, i_rst_n, eos_taken, r_scan == SCAN_RESET, "scan not reset")
    // a stalled event stays offered
    `ASSERT_NEXT(a_rsp_hold, i_clk, i_rst_n, rsp_stall, o_rsp.valid, "event dropped on stall")

endmodule
